### src/mhd_pkg.sv
`default_nettype none
package mhd_pkg;

  localparam int unsigned VarintMaxBytes = 5;
  localparam int unsigned CfgIdxW        = 2;

  typedef enum logic [2:0] {
    PH_FLAG    = 3'd0,
    PH_ID      = 3'd1,
    PH_RLEN    = 3'd2,
    PH_ROUTE   = 3'd3,
    PH_PAYWAIT = 3'd4,
    PH_PAY     = 3'd5,
    PH_DISCARD = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    K_FLAG  = 3'd0,
    K_ID    = 3'd1,
    K_RLEN  = 3'd2,
    K_ROUTE = 3'd3,
    K_PAY   = 3'd4,
    K_DISC  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_VAR_INC   = 3'd2,
    ST_RT_EMPTY  = 3'd3,
    ST_RT_COMP   = 3'd4,
    ST_RT_INC    = 3'd5,
    ST_NO_PAY    = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TYPE_MASK     = 2'd0,
    REG_COMPRESS_MASK = 2'd1,
    REG_REQUEST_CODE  = 2'd2,
    REG_RESPONSE_CODE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] type_mask;
    logic [7:0] compress_mask;
    logic [7:0] request_code;
    logic [7:0] response_code;
  } cfg_t;

  typedef struct packed {
    kind_e       byte_kind;
    logic [7:0]  out_byte;
    logic [7:0]  msg_type;
    logic        route_compressed;
    logic [31:0] msg_id;
    logic [7:0]  route_len;
    logic        end_of_message;
    status_e     status;
  } result_t;

endpackage
`default_nettype wire

### src/message_header_stream_decoder_core.sv
// Message header decoder: takes one message byte per transaction on the slave
// stream (tlast on the final byte) and returns exactly one tagged result per
// byte on the master stream, with the byte kind in tuser and the end of the
// message on tlast. A byte is parsed in the cycle it is accepted and its result
// is held in a single output register, so the block takes one byte every clock
// cycle; s_axis_tready only drops while a result sits unread in that register.
// Errors are sticky until the end of the message and the final status rides on
// the result for the last byte. Configuration writes should be made between
// messages.
`default_nettype none
module message_header_stream_decoder_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mhd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]                  cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] in_byte
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] out_byte, [15:8] msg_type, [16] route_compressed, [48:17] msg_id,
  // [56:49] route_len, [59:57] status, [63:60] zero
  output logic [63:0]                      m_axis_tdata,
  output logic [2:0]                       m_axis_tuser,  // [2:0] byte_kind
  output logic                             m_axis_tlast
);

  mhd_pkg::cfg_t    cfg;
  mhd_pkg::result_t res;
  mhd_pkg::result_t res_q;
  logic             valid_q, valid_d;
  logic             accept;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mhd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  mhd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .res_o    (res)
  );

  always_comb begin
    valid_d = valid_q;
    if (accept) valid_d = 1'b1;
    else if (m_axis_tready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = res_q.end_of_message;
  assign m_axis_tuser  = res_q.byte_kind;
  assign m_axis_tdata  = {4'd0, res_q.status, res_q.route_len, res_q.msg_id,
                          res_q.route_compressed, res_q.msg_type, res_q.out_byte};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !accept)
    else $error("result register overwritten while stalled");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted byte produced no result");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !accept |=> !m_axis_tvalid)
    else $error("result repeated after being taken");

endmodule
`default_nettype wire

### src/mhd_cfg_regs.sv
`default_nettype none
module mhd_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [mhd_pkg::CfgIdxW-1:0] idx_i,
  input  wire logic [7:0]                  wdata_i,
  output mhd_pkg::cfg_t                    cfg_o
);

  mhd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (mhd_pkg::reg_idx_e'(idx_i))
        mhd_pkg::REG_TYPE_MASK:     cfg_d.type_mask     = wdata_i;
        mhd_pkg::REG_COMPRESS_MASK: cfg_d.compress_mask = wdata_i;
        mhd_pkg::REG_REQUEST_CODE:  cfg_d.request_code  = wdata_i;
        mhd_pkg::REG_RESPONSE_CODE: cfg_d.response_code = wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_mask     <= 8'd7;
      cfg_q.compress_mask <= 8'd8;
      cfg_q.request_code  <= 8'd0;
      cfg_q.response_code <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### src/mhd_parser.sv
`default_nettype none
module mhd_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire mhd_pkg::cfg_t cfg_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output mhd_pkg::result_t res_o
);

  mhd_pkg::phase_e  phase_q, phase_d;
  logic [31:0]      id_accum_q, id_accum_d;
  logic [2:0]       id_seen_q, id_seen_d;
  logic [7:0]       route_left_q, route_left_d;
  logic [7:0]       route_len_q, route_len_d;
  logic [7:0]       type_q, type_d;
  logic             comp_q, comp_d;
  mhd_pkg::status_e err_q, err_d;

  // Values after this byte, before the end-of-message clear.
  mhd_pkg::phase_e  ph_n;
  logic [31:0]      id_n;
  logic [2:0]       seen_n;
  logic [7:0]       left_n, rlen_n, type_n;
  logic             comp_n;
  mhd_pkg::status_e err_n;
  logic [7:0]       type_masked;
  logic [31:0]      id_part;

  assign type_masked = byte_i & cfg_i.type_mask;

  always_comb begin
    unique case (id_seen_q)
      3'd0:    id_part = {25'd0, byte_i[6:0]};
      3'd1:    id_part = {18'd0, byte_i[6:0], 7'd0};
      3'd2:    id_part = {11'd0, byte_i[6:0], 14'd0};
      3'd3:    id_part = {4'd0, byte_i[6:0], 21'd0};
      3'd4:    id_part = {byte_i[3:0], 28'd0};
      default: id_part = 32'd0;
    endcase
  end

  // Next state.
  always_comb begin
    ph_n   = phase_q;
    id_n   = id_accum_q;
    seen_n = id_seen_q;
    left_n = route_left_q;
    rlen_n = route_len_q;
    type_n = type_q;
    comp_n = comp_q;
    err_n  = err_q;
    unique case (phase_q)
      mhd_pkg::PH_FLAG: begin
        type_n = type_masked;
        comp_n = |(byte_i & cfg_i.compress_mask);
        ph_n   = (type_masked == cfg_i.request_code || type_masked == cfg_i.response_code)
                 ? mhd_pkg::PH_ID : mhd_pkg::PH_RLEN;
      end
      mhd_pkg::PH_ID: begin
        if (id_seen_q >= 3'(mhd_pkg::VarintMaxBytes)) begin
          err_n = mhd_pkg::ST_TOO_LARGE;
          ph_n  = mhd_pkg::PH_DISCARD;
        end else begin
          id_n   = id_accum_q | id_part;
          seen_n = id_seen_q + 3'd1;
          if (!byte_i[7]) ph_n = mhd_pkg::PH_RLEN;
        end
      end
      mhd_pkg::PH_RLEN: begin
        if (comp_q) begin
          err_n = mhd_pkg::ST_RT_COMP;
          ph_n  = mhd_pkg::PH_DISCARD;
        end else begin
          rlen_n = byte_i;
          left_n = byte_i;
          ph_n   = (byte_i == 8'd0) ? mhd_pkg::PH_PAYWAIT : mhd_pkg::PH_ROUTE;
        end
      end
      mhd_pkg::PH_ROUTE: begin
        if (route_left_q != 8'd0) left_n = route_left_q - 8'd1;
        if (route_left_q <= 8'd1) ph_n = mhd_pkg::PH_PAYWAIT;
      end
      mhd_pkg::PH_PAYWAIT, mhd_pkg::PH_PAY: ph_n = mhd_pkg::PH_PAY;
      default: ph_n = phase_q;
    endcase
  end

  // Result for this byte.
  always_comb begin
    res_o.out_byte         = byte_i;
    res_o.msg_type         = type_n;
    res_o.route_compressed = comp_n;
    res_o.msg_id           = id_n;
    res_o.route_len        = rlen_n;
    res_o.end_of_message   = last_i;
    unique case (phase_q)
      mhd_pkg::PH_FLAG:  res_o.byte_kind = mhd_pkg::K_FLAG;
      mhd_pkg::PH_ID:    res_o.byte_kind = (ph_n == mhd_pkg::PH_DISCARD)
                                           ? mhd_pkg::K_DISC : mhd_pkg::K_ID;
      mhd_pkg::PH_RLEN:  res_o.byte_kind = (ph_n == mhd_pkg::PH_DISCARD)
                                           ? mhd_pkg::K_DISC : mhd_pkg::K_RLEN;
      mhd_pkg::PH_ROUTE: res_o.byte_kind = mhd_pkg::K_ROUTE;
      mhd_pkg::PH_PAYWAIT, mhd_pkg::PH_PAY: res_o.byte_kind = mhd_pkg::K_PAY;
      default:           res_o.byte_kind = mhd_pkg::K_DISC;
    endcase
    res_o.status = err_n;
    if (last_i && err_n == mhd_pkg::ST_OK) begin
      unique case (ph_n)
        mhd_pkg::PH_ID:      res_o.status = mhd_pkg::ST_VAR_INC;
        mhd_pkg::PH_RLEN:    res_o.status = mhd_pkg::ST_RT_EMPTY;
        mhd_pkg::PH_ROUTE:   res_o.status = mhd_pkg::ST_RT_INC;
        mhd_pkg::PH_PAYWAIT: res_o.status = mhd_pkg::ST_NO_PAY;
        default:             res_o.status = err_n;
      endcase
    end
  end

  // The last byte of a message returns every field to its idle value.
  always_comb begin
    phase_d      = phase_q;
    id_accum_d   = id_accum_q;
    id_seen_d    = id_seen_q;
    route_left_d = route_left_q;
    route_len_d  = route_len_q;
    type_d       = type_q;
    comp_d       = comp_q;
    err_d        = err_q;
    if (accept_i) begin
      if (last_i) begin
        phase_d      = mhd_pkg::PH_FLAG;
        id_accum_d   = 32'd0;
        id_seen_d    = 3'd0;
        route_left_d = 8'd0;
        route_len_d  = 8'd0;
        type_d       = 8'd0;
        comp_d       = 1'b0;
        err_d        = mhd_pkg::ST_OK;
      end else begin
        phase_d      = ph_n;
        id_accum_d   = id_n;
        id_seen_d    = seen_n;
        route_left_d = left_n;
        route_len_d  = rlen_n;
        type_d       = type_n;
        comp_d       = comp_n;
        err_d        = err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mhd_pkg::PH_FLAG;
      id_accum_q   <= 32'd0;
      id_seen_q    <= 3'd0;
      route_left_q <= 8'd0;
      route_len_q  <= 8'd0;
      type_q       <= 8'd0;
      comp_q       <= 1'b0;
      err_q        <= mhd_pkg::ST_OK;
    end else begin
      phase_q      <= phase_d;
      id_accum_q   <= id_accum_d;
      id_seen_q    <= id_seen_d;
      route_left_q <= route_left_d;
      route_len_q  <= route_len_d;
      type_q       <= type_d;
      comp_q       <= comp_d;
      err_q        <= err_d;
    end
  end

  a_discard_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mhd_pkg::PH_DISCARD) == (err_q != mhd_pkg::ST_OK))
    else $error("discard phase and sticky error disagree");

  a_id_bytes_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_seen_q <= 3'(mhd_pkg::VarintMaxBytes))
    else $error("varint byte count out of range");

  a_route_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    route_left_q <= route_len_q)
    else $error("route bytes left exceed declared length");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> phase_q == mhd_pkg::PH_FLAG && id_accum_q == 32'd0)
    else $error("state not cleared after end of message");

endmodule
`default_nettype wire
